// ===== hw/rtl/hns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hns_pkg: types and class tables for the name screen
// letter ranges with script class, look-alike set, space and wide-form tests
// ----------------------------------------------------------------------------
package hns_pkg;

   typedef enum logic [2:0] {
      CLS_NONE     = 3'd0,
      CLS_LETTER   = 3'd1,
      CLS_LATIN    = 3'd2,
      CLS_CYRILLIC = 3'd3,
      CLS_GREEK    = 3'd4
   } cls_type;

   typedef struct packed {
      logic is_space;
      logic is_letter;
      logic is_latin;
      logic is_cyrillic;
      logic is_greek;
      logic is_ascii_letter;
      logic is_mimic;
      logic is_wide;
      logic is_bin_digit;
   } unit_class_type;

   localparam int unsigned NUM_RANGES = 154;
   localparam int unsigned NUM_MIMIC  = 59;
   localparam logic [15:0] ASCII_LIMIT = 16'h0080;
   localparam logic [15:0] WIDE_DIGIT_LO = 16'hFF10;
   localparam logic [15:0] WIDE_DIGIT_HI = 16'hFF19;
   localparam logic [15:0] WIDE_UPPER_LO = 16'hFF21;
   localparam logic [15:0] WIDE_UPPER_HI = 16'hFF3A;
   localparam logic [15:0] WIDE_LOWER_LO = 16'hFF41;
   localparam logic [15:0] WIDE_LOWER_HI = 16'hFF5A;
   localparam logic [15:0] DIGIT_ZERO = 16'h0030;
   localparam logic [15:0] DIGIT_ONE  = 16'h0031;

   typedef logic [34:0] range_type;  // lo, hi, class

   localparam range_type RANGE_ROM [NUM_RANGES] = '{
      {16'h0041,16'h005A,CLS_LATIN},{16'h0061,16'h007A,CLS_LATIN},
      {16'h00AA,16'h00AA,CLS_LATIN},{16'h00B5,16'h00B5,CLS_LETTER},
      {16'h00BA,16'h00BA,CLS_LATIN},{16'h00C0,16'h00D6,CLS_LATIN},
      {16'h00D8,16'h00F6,CLS_LATIN},{16'h00F8,16'h02AF,CLS_LATIN},
      {16'h02B0,16'h02B8,CLS_LATIN},{16'h02B9,16'h02C1,CLS_LETTER},
      {16'h02C6,16'h02D1,CLS_LETTER},{16'h02E0,16'h02E4,CLS_LATIN},
      {16'h02EC,16'h02EC,CLS_LETTER},{16'h02EE,16'h02EE,CLS_LETTER},
      {16'h0370,16'h0373,CLS_GREEK},{16'h0376,16'h0377,CLS_GREEK},
      {16'h037A,16'h037D,CLS_GREEK},{16'h037F,16'h037F,CLS_GREEK},
      {16'h0386,16'h0386,CLS_GREEK},{16'h0388,16'h038A,CLS_GREEK},
      {16'h038C,16'h038C,CLS_GREEK},{16'h038E,16'h03A1,CLS_GREEK},
      {16'h03A3,16'h03E1,CLS_GREEK},{16'h03E2,16'h03EF,CLS_LETTER},
      {16'h03F0,16'h03F5,CLS_GREEK},{16'h03F7,16'h03FF,CLS_GREEK},
      {16'h0400,16'h0481,CLS_CYRILLIC},{16'h048A,16'h052F,CLS_CYRILLIC},
      {16'h0531,16'h0556,CLS_LETTER},{16'h0559,16'h0559,CLS_LETTER},
      {16'h0560,16'h0588,CLS_LETTER},{16'h05D0,16'h05EA,CLS_LETTER},
      {16'h05EF,16'h05F2,CLS_LETTER},{16'h0620,16'h064A,CLS_LETTER},
      {16'h066E,16'h066F,CLS_LETTER},{16'h0671,16'h06D3,CLS_LETTER},
      {16'h06D5,16'h06D5,CLS_LETTER},{16'h06E5,16'h06E6,CLS_LETTER},
      {16'h06EE,16'h06EF,CLS_LETTER},{16'h06FA,16'h06FC,CLS_LETTER},
      {16'h06FF,16'h06FF,CLS_LETTER},{16'h0710,16'h0710,CLS_LETTER},
      {16'h0712,16'h072F,CLS_LETTER},{16'h074D,16'h07A5,CLS_LETTER},
      {16'h07B1,16'h07B1,CLS_LETTER},{16'h0904,16'h0939,CLS_LETTER},
      {16'h093D,16'h093D,CLS_LETTER},{16'h0950,16'h0950,CLS_LETTER},
      {16'h0958,16'h0961,CLS_LETTER},{16'h0971,16'h0980,CLS_LETTER},
      {16'h0E01,16'h0E30,CLS_LETTER},{16'h0E32,16'h0E33,CLS_LETTER},
      {16'h0E40,16'h0E46,CLS_LETTER},{16'h10A0,16'h10C5,CLS_LETTER},
      {16'h10D0,16'h10FA,CLS_LETTER},{16'h10FC,16'h1248,CLS_LETTER},
      {16'h124A,16'h135A,CLS_LETTER},{16'h13A0,16'h13F5,CLS_LETTER},
      {16'h13F8,16'h13FD,CLS_LETTER},{16'h1401,16'h166C,CLS_LETTER},
      {16'h166F,16'h167F,CLS_LETTER},{16'h1820,16'h1878,CLS_LETTER},
      {16'h1C80,16'h1C88,CLS_CYRILLIC},{16'h1D00,16'h1D25,CLS_LATIN},
      {16'h1D26,16'h1D2A,CLS_GREEK},{16'h1D2B,16'h1D2B,CLS_CYRILLIC},
      {16'h1D2C,16'h1D5C,CLS_LATIN},{16'h1D5D,16'h1D61,CLS_GREEK},
      {16'h1D62,16'h1D65,CLS_LATIN},{16'h1D66,16'h1D6A,CLS_GREEK},
      {16'h1D6B,16'h1D77,CLS_LATIN},{16'h1D78,16'h1D78,CLS_CYRILLIC},
      {16'h1D79,16'h1DBE,CLS_LATIN},{16'h1DBF,16'h1DBF,CLS_GREEK},
      {16'h1E00,16'h1EFF,CLS_LATIN},{16'h1F00,16'h1F15,CLS_GREEK},
      {16'h1F18,16'h1F1D,CLS_GREEK},{16'h1F20,16'h1F45,CLS_GREEK},
      {16'h1F48,16'h1F4D,CLS_GREEK},{16'h1F50,16'h1F57,CLS_GREEK},
      {16'h1F59,16'h1F59,CLS_GREEK},{16'h1F5B,16'h1F5B,CLS_GREEK},
      {16'h1F5D,16'h1F5D,CLS_GREEK},{16'h1F5F,16'h1F7D,CLS_GREEK},
      {16'h1F80,16'h1FB4,CLS_GREEK},{16'h1FB6,16'h1FBC,CLS_GREEK},
      {16'h1FBE,16'h1FBE,CLS_GREEK},{16'h1FC2,16'h1FC4,CLS_GREEK},
      {16'h1FC6,16'h1FCC,CLS_GREEK},{16'h1FD0,16'h1FD3,CLS_GREEK},
      {16'h1FD6,16'h1FDB,CLS_GREEK},{16'h1FE0,16'h1FEC,CLS_GREEK},
      {16'h1FF2,16'h1FF4,CLS_GREEK},{16'h1FF6,16'h1FFC,CLS_GREEK},
      {16'h2071,16'h2071,CLS_LATIN},{16'h207F,16'h207F,CLS_LATIN},
      {16'h2090,16'h209C,CLS_LATIN},{16'h2102,16'h2102,CLS_LETTER},
      {16'h2107,16'h2107,CLS_LETTER},{16'h210A,16'h2113,CLS_LETTER},
      {16'h2115,16'h2115,CLS_LETTER},{16'h2119,16'h211D,CLS_LETTER},
      {16'h2124,16'h2124,CLS_LETTER},{16'h2126,16'h2126,CLS_GREEK},
      {16'h2128,16'h2128,CLS_LETTER},{16'h212A,16'h212B,CLS_LATIN},
      {16'h212C,16'h212D,CLS_LETTER},{16'h212F,16'h2131,CLS_LETTER},
      {16'h2132,16'h2132,CLS_LATIN},{16'h2133,16'h2139,CLS_LETTER},
      {16'h213C,16'h213F,CLS_LETTER},{16'h2145,16'h2149,CLS_LETTER},
      {16'h214E,16'h214E,CLS_LATIN},{16'h2183,16'h2184,CLS_LATIN},
      {16'h2C60,16'h2C7F,CLS_LATIN},{16'h3005,16'h3006,CLS_LETTER},
      {16'h3031,16'h3035,CLS_LETTER},{16'h303B,16'h303C,CLS_LETTER},
      {16'h3041,16'h3096,CLS_LETTER},{16'h309D,16'h309F,CLS_LETTER},
      {16'h30A1,16'h30FA,CLS_LETTER},{16'h30FC,16'h30FF,CLS_LETTER},
      {16'h3105,16'h312F,CLS_LETTER},{16'h3400,16'h4DBF,CLS_LETTER},
      {16'h4E00,16'h9FFF,CLS_LETTER},{16'hA000,16'hA48C,CLS_LETTER},
      {16'hA640,16'hA66E,CLS_CYRILLIC},{16'hA67F,16'hA69D,CLS_CYRILLIC},
      {16'hA722,16'hA787,CLS_LATIN},{16'hA788,16'hA788,CLS_LETTER},
      {16'hA78B,16'hA7FF,CLS_LATIN},{16'hAB30,16'hAB5A,CLS_LATIN},
      {16'hAB5C,16'hAB64,CLS_LATIN},{16'hAB65,16'hAB65,CLS_GREEK},
      {16'hAC00,16'hD7A3,CLS_LETTER},{16'hF900,16'hFA6D,CLS_LETTER},
      {16'hFA70,16'hFAD9,CLS_LETTER},{16'hFB00,16'hFB06,CLS_LATIN},
      {16'hFB1D,16'hFB28,CLS_LETTER},{16'hFB2A,16'hFB4F,CLS_LETTER},
      {16'hFB50,16'hFBB1,CLS_LETTER},{16'hFBD3,16'hFD3D,CLS_LETTER},
      {16'hFD50,16'hFD8F,CLS_LETTER},{16'hFD92,16'hFDC7,CLS_LETTER},
      {16'hFDF0,16'hFDFB,CLS_LETTER},{16'hFE70,16'hFE74,CLS_LETTER},
      {16'hFE76,16'hFEFC,CLS_LETTER},{16'hFF21,16'hFF3A,CLS_LATIN},
      {16'hFF41,16'hFF5A,CLS_LATIN},{16'hFF66,16'hFFBE,CLS_LETTER},
      {16'hFFC2,16'hFFC7,CLS_LETTER},{16'hFFCA,16'hFFCF,CLS_LETTER},
      {16'hFFD2,16'hFFD7,CLS_LETTER},{16'hFFDA,16'hFFDC,CLS_LETTER}
   };

   localparam logic [15:0] MIMIC_ROM [NUM_MIMIC] = '{
      16'h0410,16'h0412,16'h0415,16'h041A,16'h041C,16'h041D,16'h041E,16'h0420,
      16'h0421,16'h0422,16'h0423,16'h0425,16'h0406,16'h0408,16'h0405,16'h04C0,
      16'h051A,16'h051C,16'h0430,16'h0432,16'h0435,16'h043A,16'h043C,16'h043E,
      16'h0440,16'h0441,16'h0442,16'h0443,16'h0445,16'h0456,16'h0458,16'h0455,
      16'h04CF,16'h051B,16'h051D,16'h0391,16'h0392,16'h0395,16'h0396,16'h0397,
      16'h0399,16'h039A,16'h039C,16'h039D,16'h039F,16'h03A1,16'h03A4,16'h03A5,
      16'h03A7,16'h03F9,16'h03B1,16'h03B9,16'h03BA,16'h03BD,16'h03BF,16'h03C1,
      16'h03C5,16'h03C7,16'h03F2
   };

   // ranges are disjoint, so an or over all matches gives the class
   function automatic cls_type class_of(input logic [15:0] c);
      logic [2:0] acc;
      acc = '0;
      for (int k = 0; k < NUM_RANGES; k++) begin
         if (c >= RANGE_ROM[k][34:19] && c <= RANGE_ROM[k][18:3]) begin
            acc = acc | RANGE_ROM[k][2:0];
         end
      end
      return cls_type'(acc);
   endfunction

   function automatic logic is_mimic(input logic [15:0] c);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < NUM_MIMIC; k++) begin
         hit = hit | (c == MIMIC_ROM[k]);
      end
      return hit;
   endfunction

   function automatic logic is_space(input logic [15:0] c);
      return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
             c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
             c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
             c == 16'h3000;
   endfunction

endpackage

// ===== hw/rtl/hns_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hns_classify: code unit class lookup
// maps one code unit onto its letter, script, space, look-alike, wide-form and binary-digit flags
// ----------------------------------------------------------------------------
module hns_classify (
   input  logic [15:0]                 code_unit,
   output hns_pkg::unit_class_type     unit_class
);
   import hns_pkg::*;

   cls_type cls;

   always_comb begin
      cls = class_of(code_unit);
      unit_class.is_space        = is_space(code_unit);
      unit_class.is_letter       = (cls != CLS_NONE);
      unit_class.is_latin        = (cls == CLS_LATIN);
      unit_class.is_cyrillic     = (cls == CLS_CYRILLIC);
      unit_class.is_greek        = (cls == CLS_GREEK);
      unit_class.is_ascii_letter = (code_unit < ASCII_LIMIT) && (cls != CLS_NONE);
      unit_class.is_mimic        = is_mimic(code_unit);
      unit_class.is_wide         = (code_unit >= WIDE_DIGIT_LO && code_unit <= WIDE_DIGIT_HI)
         || (code_unit >= WIDE_UPPER_LO && code_unit <= WIDE_UPPER_HI)
         || (code_unit >= WIDE_LOWER_LO && code_unit <= WIDE_LOWER_HI);
      unit_class.is_bin_digit    = (code_unit == DIGIT_ZERO) || (code_unit == DIGIT_ONE);
   end

endmodule

// ===== hw/rtl/hns_word_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hns_word_state: per-word flag tracker
// updates word flags for one classified unit and yields the verdict on last
// ----------------------------------------------------------------------------
module hns_word_state (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        last_unit,
   input  hns_pkg::unit_class_type     unit_class,
   output logic                        verdict
);
   import hns_pkg::*;

   logic latin_ff, cyr_ff, greek_ff, ascii_ff, mimic_ff;
   logic run_ff, before_ff, prev_ff, flag_ff;
   logic latin_in, cyr_in, greek_in, ascii_in, mimic_in;
   logic run_in, before_in, prev_in, flag_in;
   logic [1:0] scripts;

   always_comb begin
      latin_in  = latin_ff;
      cyr_in    = cyr_ff;
      greek_in  = greek_ff;
      ascii_in  = ascii_ff;
      mimic_in  = mimic_ff;
      run_in    = run_ff;
      before_in = before_ff;
      prev_in   = prev_ff;
      flag_in   = flag_ff;
      scripts   = '0;
      if (unit_class.is_space) begin
         latin_in  = 1'b0;
         cyr_in    = 1'b0;
         greek_in  = 1'b0;
         ascii_in  = 1'b0;
         mimic_in  = 1'b0;
         run_in    = 1'b0;
         before_in = 1'b0;
         prev_in   = 1'b0;
      end else begin
         latin_in = latin_ff | unit_class.is_latin;
         cyr_in   = cyr_ff | unit_class.is_cyrillic;
         greek_in = greek_ff | unit_class.is_greek;
         ascii_in = ascii_ff | unit_class.is_ascii_letter;
         mimic_in = mimic_ff | unit_class.is_mimic;
         scripts  = 2'(latin_in) + 2'(cyr_in) + 2'(greek_in);
         if (unit_class.is_wide || scripts >= 2'd2 || (mimic_in && ascii_in)) begin
            flag_in = 1'b1;
         end
         if (unit_class.is_bin_digit) begin
            if (!run_ff) begin
               run_in    = 1'b1;
               before_in = prev_ff;
            end
            prev_in = 1'b0;
         end else begin
            if (run_ff) begin
               if (unit_class.is_letter && before_ff) begin
                  flag_in = 1'b1;
               end
               run_in    = 1'b0;
               before_in = 1'b0;
            end
            prev_in = unit_class.is_letter;
         end
      end
      verdict = flag_in;
      if (last_unit) begin
         latin_in  = 1'b0;
         cyr_in    = 1'b0;
         greek_in  = 1'b0;
         ascii_in  = 1'b0;
         mimic_in  = 1'b0;
         run_in    = 1'b0;
         before_in = 1'b0;
         prev_in   = 1'b0;
         flag_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latin_ff  <= 1'b0;
         cyr_ff    <= 1'b0;
         greek_ff  <= 1'b0;
         ascii_ff  <= 1'b0;
         mimic_ff  <= 1'b0;
         run_ff    <= 1'b0;
         before_ff <= 1'b0;
         prev_ff   <= 1'b0;
         flag_ff   <= 1'b0;
      end else if (step) begin
         latin_ff  <= latin_in;
         cyr_ff    <= cyr_in;
         greek_ff  <= greek_in;
         ascii_ff  <= ascii_in;
         mimic_ff  <= mimic_in;
         run_ff    <= run_in;
         before_ff <= before_in;
         prev_ff   <= prev_in;
         flag_ff   <= flag_in;
      end
   end

endmodule

// ===== hw/rtl/homoglyph_name_screen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homoglyph_name_screen: display name spoof screen
// one code unit per beat; a verdict beat follows each last unit
// ----------------------------------------------------------------------------
// verdict path: the last unit leaves the input register stage and its verdict enters the output register
// throughput: one code unit per cycle, set by the input register stage and
// the single-entry output register; a last unit stalls while the held verdict is not taken
// reset: synchronous; clears the input stage, word flags and output valid
module homoglyph_name_screen (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // code_unit
   input  logic        req_tlast,   // last_unit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // suspicious, zero fill
);
   import hns_pkg::*;

   logic            in_valid_ff;
   logic [15:0]     unit_ff;
   logic            last_ff;
   logic            out_valid_ff;
   logic            out_flag_ff;
   logic            stage_go;
   logic            verdict;
   unit_class_type  unit_class;

   // stage moves when its result (if any) can enter the output register
   assign stage_go   = in_valid_ff && (!last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || stage_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         unit_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   hns_classify u_classify (
      .code_unit  (unit_ff),
      .unit_class (unit_class)
   );

   hns_word_state u_word_state (
      .clock      (clock),
      .reset      (reset),
      .step       (stage_go),
      .last_unit  (last_ff),
      .unit_class (unit_class),
      .verdict    (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stage_go && last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_go && last_ff) begin
         out_flag_ff <= verdict;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_flag_ff};

endmodule
